/* hw/rtl/tmtw_pkg.sv */
`timescale 1ns / 1ps

package tmtw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CELL_W  = 16;
    localparam int COLOR_W = 8;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int CROW_W  = 5;
    localparam int CCOL_W  = 7;

    localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0720;
    localparam logic [CELL_W-1:0]  ZERO_CELL    = 16'h0000;
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;

    // s_tdata: char_code [7:0], read_index [18:8], zero pad to 24 bits
    localparam int S_DATA_W = 24;
    // m_tdata: cell_index, cell_entry, cursor_row, cursor_col, scrolled
    localparam int M_DATA_W = 40;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_READ = 5'b00100,
        ST_COPY = 5'b01000,
        ST_FILL = 5'b10000
    } state_t;

endpackage

/* hw/rtl/tmtw_screen_ram.sv */
`timescale 1ns / 1ps

module tmtw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tmtw_pkg::CELL_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [tmtw_pkg::CELL_W-1:0] rdata
);
    import tmtw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/text_mode_terminal_writer.sv */
`timescale 1ns / 1ps
// Text console: a COLUMNS x ROWS screen of 16-bit cells and a cursor.
// Input stream (s_*): one request per character put or cell read;
//   tuser is the opcode (0 put, 1 read), tlast marks the end of a string.
// Output stream (m_*): exactly one result per request, in request order;
//   tuser is the wrote flag, tlast echoes the end-of-string mark.
// cfg_we/cfg_wdata write the attribute byte used for stored characters.
// Results: a put has its result registered at acceptance, even when
//   it scrolls; a read's result is registered in ST_READ from the RAM read.
// Throughput: one request per cycle for puts while the output register is
//   free; no request is taken while a read is in ST_READ. A put that runs
//   off the bottom row scrolls: the screen RAM is copied one cell per
//   cycle through its single write port and the bottom row is zeroed,
//   keeping the input blocked until the bottom row is zeroed.
// Reset: cursor to the top-left corner, attribute to 0x07; then a
//   clearing pass writes 0x0720 to every cell, during which no request
//   is taken.
// Stall: results sit in an output register; a new request is taken only
//   when that register is empty or being emptied in the same cycle.

module text_mode_terminal_writer #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tmtw_pkg::COLOR_W-1:0]     cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tmtw_pkg::S_DATA_W-1:0]    s_tdata,  // char_code, read_index, pad
    input  logic                             s_tuser,  // opcode
    input  logic                             s_tlast,  // end_of_string
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tmtw_pkg::M_DATA_W-1:0]    m_tdata,  // cell_index, cell_entry,
                                                       // cursor_row, cursor_col, scrolled
    output logic                             m_tuser,  // wrote
    output logic                             m_tlast   // string_done
);
    import tmtw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);

    localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0]    LAST_A    = AW'(CELLS - 1);
    localparam logic [AW-1:0]    FILL_A    = AW'(CELLS - COLUMNS);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [31:0]      CELLS_32  = 32'(CELLS);

    state_t state_reg, state_next;

    logic [COLOR_W-1:0] color_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [AW-1:0]      base_reg, base_next;     // row_reg * COLUMNS
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;

    logic [IDX_W-1:0]   ridx_reg, ridx_next;
    logic               oor_reg, oor_next;
    logic               eos_reg, eos_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;
    logic               m_tlast_reg, m_tlast_next;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    logic [CHAR_W-1:0]  in_char;
    logic [IDX_W-1:0]   in_ridx;
    logic [31:0]        ridx_ext;
    logic               accept;
    logic               out_free;

    logic [AW-1:0]      put_addr;
    logic [31:0]        put_addr_ext;
    logic [31:0]        row_ext, col_ext;
    logic               adv_row;
    logic               do_scroll;
    logic [CELL_W-1:0]  res_entry;
    logic [IDX_W-1:0]   res_idx;
    logic               res_wrote;

    tmtw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_char  = s_tdata[CHAR_W-1:0];
    assign in_ridx  = s_tdata[CHAR_W +: IDX_W];
    assign ridx_ext = 32'(in_ridx);

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign put_addr     = base_reg + AW'(col_reg);
    assign put_addr_ext = 32'(put_addr);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        ridx_next      = ridx_reg;
        oor_next       = oor_reg;
        eos_next       = eos_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;

        ram_we    = 1'b0;
        ram_waddr = put_addr;
        ram_wdata = {color_reg, in_char};
        ram_re    = 1'b0;
        ram_raddr = ridx_ext[AW-1:0];

        adv_row   = 1'b0;
        do_scroll = 1'b0;
        res_entry = ZERO_CELL;
        res_idx   = '0;
        res_wrote = 1'b0;
        row_ext   = '0;
        col_ext   = '0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = BLANK_CELL;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST_A)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_READ)
                    begin
                        ram_re     = 1'b1;
                        ridx_next  = in_ridx;
                        oor_next   = ridx_ext >= CELLS_32;
                        eos_next   = s_tlast;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        if (in_char == NEWLINE_CODE)
                        begin
                            col_next = '0;
                            adv_row  = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            res_wrote = 1'b1;
                            res_entry = {color_reg, in_char};
                            res_idx   = put_addr_ext[IDX_W-1:0];
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                adv_row  = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end

                        if (adv_row)
                        begin
                            if (row_reg == LAST_ROW)
                            begin
                                do_scroll  = 1'b1;
                                cnt_next   = COLS_A;
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                row_next  = row_reg + ROW_W'(1);
                                base_next = base_reg + COLS_A;
                            end
                        end

                        // result is final at acceptance, even when a scroll follows
                        row_ext = 32'(row_next);
                        col_ext = 32'(col_next);
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = res_wrote;
                        m_tlast_next  = s_tlast;
                        m_tdata_next  = {do_scroll, col_ext[CCOL_W-1:0],
                                         row_ext[CROW_W-1:0], res_entry, res_idx};
                    end
                end
            end

            ST_READ:
            begin
                row_ext = 32'(row_reg);
                col_ext = 32'(col_reg);
                m_tvalid_next = 1'b1;
                m_tuser_next  = 1'b0;
                m_tlast_next  = eos_reg;
                m_tdata_next  = {1'b0, col_ext[CCOL_W-1:0], row_ext[CROW_W-1:0],
                                 oor_reg ? ZERO_CELL : ram_rdata, ridx_reg};
                state_next    = ST_IDLE;
            end

            ST_COPY:
            begin
                // read cell cnt, write it one row up on the next cycle
                ram_re         = 1'b1;
                ram_raddr      = cnt_reg;
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg - COLS_A;
                ram_we         = pend_reg;
                ram_waddr      = pend_addr_reg;
                ram_wdata      = ram_rdata;
                if (cnt_reg == LAST_A)
                begin
                    cnt_next   = FILL_A;
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            ST_FILL:
            begin
                ram_we = 1'b1;
                if (pend_reg)
                begin
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    ram_waddr = cnt_reg;
                    ram_wdata = ZERO_CELL;
                    cnt_next  = cnt_reg + AW'(1);
                    if (cnt_reg == LAST_A)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            color_reg    <= COLOR_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        ridx_reg      <= ridx_next;
        oor_reg       <= oor_next;
        eos_reg       <= eos_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // a request is never taken while an unconsumed result would be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!m_tvalid_reg || m_tready))
        else $error("request accepted over a pending result");

    // row base always tracks the cursor row, and the cursor column stays below COLUMNS
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(base_reg) == 32'(row_reg) * COLUMNS) && (32'(col_reg) < COLUMNS))
        else $error("cursor state inconsistent");

    // in idle the RAM is written only by an accepted character put
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && ram_we) |->
            (accept && s_tuser == OP_PUT && in_char != NEWLINE_CODE))
        else $error("stray screen write");

    // a scroll always ends with the cursor on the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && state_next == ST_IDLE) |-> (row_reg == LAST_ROW))
        else $error("scroll ended off the last row");

endmodule

/* dv/text_mode_terminal_writer_tb.sv */
`timescale 1ns / 1ps

module text_mode_terminal_writer_tb;

    import tmtw_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int QUIET_LIMIT = 20000;  // clear pass or scroll plus stalls, with margin
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 325;

    typedef struct packed {
        logic                wrote;
        logic [IDX_W-1:0]    idx;
        logic [CELL_W-1:0]   entry;
        logic [CROW_W-1:0]   row;
        logic [CCOL_W-1:0]   col;
        logic                scrolled;
        logic                done;
    } term_result_t;

    // Shadow screen, cursor and attribute; one awaited result per request.
    class screen_tracker;
        logic [CELL_W-1:0]  cells [CELLS];
        logic [CROW_W-1:0]  row;
        logic [CCOL_W-1:0]  col;
        logic [COLOR_W-1:0] attr;
        term_result_t       awaited [$];
        int                 mismatches;

        function new();
            foreach (cells[i])
            begin
                cells[i] = BLANK_CELL;
            end
            row        = '0;
            col        = '0;
            attr       = COLOR_RESET;
            mismatches = 0;
        endfunction

        function void set_color(logic [COLOR_W-1:0] c);
            attr = c;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(string what, int unsigned got_v, int unsigned want_v);
            mismatches++;
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got_v,
                     want_v);
        endtask

        // Cursor down one row; at the bottom the screen moves up and the last row zeroes.
        function logic advance_row();
            if (row + 1 >= ROWS)
            begin
                for (int i = 0; i < CELLS - COLUMNS; i++)
                begin
                    cells[i] = cells[i + COLUMNS];
                end
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                begin
                    cells[i] = ZERO_CELL;
                end
                row = CROW_W'(ROWS - 1);
                return 1'b1;
            end
            row = CROW_W'(row + 1);
            return 1'b0;
        endfunction

        function void note_request(opcode_t op, logic [CHAR_W-1:0] ch,
                                   logic [IDX_W-1:0] ridx, logic eos);
            term_result_t r;
            int unsigned  pos;
            r = '0;
            if (op == OP_READ)
            begin
                r.idx = ridx;
                if (ridx < CELLS)
                begin
                    r.entry = cells[ridx];
                end
            end
            else if (ch == NEWLINE_CODE)
            begin
                col        = '0;
                r.scrolled = advance_row();
            end
            else
            begin
                pos        = row * COLUMNS + col;
                r.idx      = IDX_W'(pos);
                r.entry    = {attr, ch};
                cells[pos] = r.entry;
                r.wrote    = 1'b1;
                col        = CCOL_W'(col + 1);
                if (col >= COLUMNS)
                begin
                    col        = '0;
                    r.scrolled = advance_row();
                end
            end
            r.row  = row;
            r.col  = col;
            r.done = eos;
            awaited.push_back(r);
        endfunction

        task check_result(term_result_t got);
            term_result_t want;
            if (awaited.size() == 0)
            begin
                report("result with nothing awaited", got.idx, 0);
                return;
            end
            want = awaited.pop_front();
            if (got.wrote !== want.wrote)
                report("wrote", got.wrote, want.wrote);
            if (got.idx !== want.idx)
                report("cell_index", got.idx, want.idx);
            if (got.entry !== want.entry)
                report("cell_entry", got.entry, want.entry);
            if (got.row !== want.row)
                report("cursor_row", got.row, want.row);
            if (got.col !== want.col)
                report("cursor_col", got.col, want.col);
            if (got.scrolled !== want.scrolled)
                report("scrolled", got.scrolled, want.scrolled);
            if (got.done !== want.done)
                report("string_done", got.done, want.done);
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [COLOR_W-1:0]  cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // char_code, read_index, zero pad
    logic                s_tuser   = 1'b0;  // opcode
    logic                s_tlast   = 1'b0;  // end_of_string
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;  // cell_index, cell_entry, cursor_row, cursor_col, scrolled
    logic                m_tuser;  // wrote
    logic                m_tlast;  // string_done

    screen_tracker sb = new();

    int items_sent   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    int calm_left    = 0;
    bit sender_calm  = 1'b0;

    text_mode_terminal_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Accepted requests feed the shadow screen; accepted results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_request(opcode_t'(s_tuser), s_tdata[7:0], s_tdata[18:8], s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_result('{wrote: m_tuser, idx: m_tdata[10:0], entry: m_tdata[26:11],
                                  row: m_tdata[31:27], col: m_tdata[38:32],
                                  scrolled: m_tdata[39], done: m_tlast});
            end
        end
    end

    // Receiver: mostly ready, short and long stalls, and calm stretches.
    always @(posedge clk)
    begin
        int roll;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            m_tready <= 1'b1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                m_tready <= 1'b1;
            end
            else if (roll < 90)
            begin
                hold_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else if (roll < 95)
            begin
                hold_left = $urandom_range(10, 50);
                m_tready <= 1'b0;
            end
            else
            begin
                calm_left = $urandom_range(50, 300);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[text_mode_terminal_writer] ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(opcode_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] ridx,
                                logic eos);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        gap  = 0;
        if (!sender_calm)
        begin
            if (roll < 30)
                gap = $urandom_range(1, 3);
            else if (roll < 36)
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= eos;
        s_tdata  <= {5'b0, ridx, ch};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Sender holds off until every outstanding result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_color(logic [COLOR_W-1:0] c);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_color(c);
    endtask

    task automatic read_somewhere();
        int roll;
        int base;
        logic [IDX_W-1:0] ridx;
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            // near the cursor, where recent characters landed
            base = int'(sb.row) - int'($urandom_range(0, 2));
            if (base < 0)
                base = 0;
            ridx = IDX_W'(base * COLUMNS + int'($urandom_range(0, COLUMNS - 1)));
        end
        else if (roll < 85)
        begin
            ridx = IDX_W'($urandom_range(0, CELLS - 1));
        end
        else
        begin
            ridx = IDX_W'($urandom_range(CELLS, 2047));
        end
        send_request(OP_READ, CHAR_W'($urandom_range(0, 255)), ridx,
                     1'($urandom_range(0, 1)));
    endtask

    task automatic type_string();
        int len;
        int roll;
        logic [CHAR_W-1:0] ch;
        logic eos;
        bit broken;
        sender_calm = ($urandom_range(0, 4) == 0);
        broken      = ($urandom_range(0, 29) == 0);
        len         = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30)
                                                    : $urandom_range(60, 130);
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                ch = NEWLINE_CODE;
            else if (roll < 80)
                ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
            else
                ch = CHAR_W'($urandom_range(0, 255));
            eos = (i == len - 1) ? !broken : ($urandom_range(0, 32) == 0);
            send_request(OP_PUT, ch, IDX_W'($urandom_range(0, 2047)), eos);
        end
        repeat ($urandom_range(0, 3)) read_somewhere();
    endtask

    initial
    begin
        logic [COLOR_W-1:0] phase_color [PHASES];
        int phase_start;
        phase_color = '{8'h00, 8'hFF, 8'h00, 8'hA5, 8'h00, 8'h1F};
        phase_color[2] = COLOR_W'($urandom_range(0, 255));
        phase_color[4] = COLOR_W'($urandom_range(0, 255));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset screen, range edges, null/space/0xFF bytes, newline, ignored fields
        send_request(OP_READ, 8'h00, 11'd0, 1'b0);
        send_request(OP_READ, 8'h00, 11'd1999, 1'b0);
        send_request(OP_READ, 8'h00, 11'd2000, 1'b1);
        send_request(OP_READ, 8'hFF, 11'd2047, 1'b0);
        send_request(OP_PUT, 8'h41, 11'd0, 1'b0);
        send_request(OP_PUT, 8'h00, 11'd0, 1'b0);
        send_request(OP_PUT, 8'h20, 11'd0, 1'b0);
        send_request(OP_PUT, 8'hFF, 11'd2047, 1'b1);
        send_request(OP_READ, 8'h00, 11'd1, 1'b0);
        send_request(OP_READ, 8'h00, 11'd3, 1'b0);
        send_request(OP_PUT, NEWLINE_CODE, 11'd0, 1'b0);
        send_request(OP_PUT, 8'h78, 11'd0, 1'b0);
        send_request(OP_PUT, NEWLINE_CODE, 11'd2047, 1'b1);
        send_request(OP_PUT, 8'h42, 11'd2047, 1'b0);
        send_request(OP_READ, 8'hFF, 11'd80, 1'b1);
        send_request(OP_READ, 8'h00, 11'd160, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_color(phase_color[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                type_string();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[text_mode_terminal_writer] OK");
        else
            $display("[text_mode_terminal_writer] ERROR");
        $finish;
    end

endmodule
